// ----- hw/rtl/abpw_pkg.sv -----
// shared types, constants and helper functions for the advertising frame builder
package abpw_pkg;

    // frame geometry
    localparam int FRAME_LEN = 31;
    localparam int HDR_LEN   = 5;
    localparam int REC_BASE  = 7;
    localparam int IDX_W     = 5;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    // whitening generator
    localparam logic [6:0] LFSR_SEED    = 7'h53;
    localparam int         WARMUP_BYTES = 13;

    // crc constants
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // record sync byte choices
    localparam logic [7:0] SYNC_HI = 8'hAA;
    localparam logic [7:0] SYNC_LO = 8'h55;

    // stream widths
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRP_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROFILE  = 2'd2;

    // request queue depth
    localparam int QUEUE_DEPTH = 2;

    // one queued request, with the random-byte mixing already done
    typedef struct packed {
        logic [7:0] seq_lo;
        logic [7:0] seq_hi_x;
        logic [7:0] cmd;
        logic [7:0] pay0;
        logic [7:0] pay1;
        logic [7:0] extra;
        logic [7:0] prof_x;
        logic [7:0] rnd;
    } abpw_entry_t;

    // static address configuration seen by the frame engine
    typedef struct packed {
        logic [39:0] dev_addr;
        logic [15:0] grp_addr;
    } abpw_cfg_t;

    // whitening step result
    typedef struct packed {
        logic [6:0] state;
        logic [7:0] mask;
    } abpw_lfsr_t;

    // eight lfsr ticks, lsb of the mask first
    function automatic abpw_lfsr_t lfsr_byte(input logic [6:0] s_in);
        abpw_lfsr_t r;
        logic [6:0] s;
        logic       w;
        s = s_in;
        r.mask = '0;
        for (int b = 0; b < 8; b++) begin
            w = s[6];
            r.mask[b] = w;
            s = {s[5:0], w};
            if (w) begin
                s = s ^ 7'h10;
            end
        end
        r.state = s;
        return r;
    endfunction

    // generator state after the warm-up run, folded at elaboration
    function automatic logic [6:0] lfsr_warm();
        abpw_lfsr_t r;
        logic [6:0] s;
        s = LFSR_SEED;
        for (int i = 0; i < WARMUP_BYTES; i++) begin
            r = lfsr_byte(s);
            s = r.state;
        end
        return s;
    endfunction

    localparam logic [6:0] LFSR_WARM = lfsr_warm();

    // one byte of msb-first ccitt crc
    function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] d);
        logic [15:0] c;
        c = c_in ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int b = 0; b < 8; b++) begin
            r[b] = v[7-b];
        end
        return r;
    endfunction

    // fixed frame header
    function automatic logic [7:0] hdr_byte(input logic [IDX_W-1:0] i);
        logic [7:0] r;
        case (i)
            5'd0:    r = 8'h02;
            5'd1:    r = 8'h01;
            5'd2:    r = 8'h01;
            5'd3:    r = 8'h1B;
            5'd4:    r = 8'h03;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- hw/rtl/ble_adv_packet_builder_whitened.sv -----
// Top level of the whitened advertising frame builder.
// The request passes through the request queue and the output register before its
// first frame byte is valid. The result channel carries one frame byte per cycle
// while m_tready holds, and the request queue (QUEUE_DEPTH entries) lets requests
// arrive during a frame.
// Reset: synchronous active-low aresetn clears configuration, queue and output.
module ble_adv_packet_builder_whitened #(
    parameter int QUEUE_DEPTH = abpw_pkg::QUEUE_DEPTH
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [abpw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [abpw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // sequence_req[15:0], command_code[23:16], payload_byte0[31:24],
    // payload_byte1[39:32], extra_param[47:40], random_byte[55:48]
    input  logic [abpw_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // frame_byte[7:0], byte_index[12:8], zero[15:13]
    output logic [abpw_pkg::M_DATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);
    import abpw_pkg::*;

    logic        q_full;
    logic        q_push;
    logic        q_pop;
    logic        q_not_empty;
    abpw_entry_t q_entry;
    abpw_entry_t q_head;
    abpw_cfg_t   cfg;

    // request intake and configuration
    abpw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry),
        .cfg_out   (cfg)
    );

    // decoupling queue
    abpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .full       (q_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    // frame engine
    abpw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .cfg_in      (cfg),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ----- hw/rtl/abpw_front.sv -----
// front end: configuration registers and request unpacking into queue entries
module abpw_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [abpw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [abpw_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // sequence_req[15:0], command_code[23:16], payload_byte0[31:24],
    // payload_byte1[39:32], extra_param[47:40], random_byte[55:48]
    input  logic [abpw_pkg::S_DATA_W-1:0]  s_tdata,
    input  logic                           q_full,
    output logic                           q_push,
    output abpw_pkg::abpw_entry_t          q_entry,
    output abpw_pkg::abpw_cfg_t            cfg_out
);
    import abpw_pkg::*;

    logic [39:0] dev_addr_reg;
    logic [15:0] grp_addr_reg;
    logic [7:0]  profile_reg;
    logic [7:0]  rnd;

    assign cfg_ready = 1'b1;

    // configuration register writes, unknown indexes dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_addr_reg <= '0;
            grp_addr_reg <= '0;
            profile_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_DEV_ADDR: dev_addr_reg <= cfg_data[39:0];
                CFG_GRP_ADDR: grp_addr_reg <= cfg_data[15:0];
                CFG_PROFILE:  profile_reg  <= cfg_data[7:0];
                default:      ;
            endcase
        end
    end

    assign cfg_out.dev_addr = dev_addr_reg;
    assign cfg_out.grp_addr = grp_addr_reg;

    // request accept while the queue has room
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // unpack and premix with the random byte
    assign rnd              = s_tdata[55:48];
    assign q_entry.seq_lo   = s_tdata[7:0];
    assign q_entry.seq_hi_x = s_tdata[15:8] ^ rnd;
    assign q_entry.cmd      = s_tdata[23:16];
    assign q_entry.pay0     = s_tdata[31:24];
    assign q_entry.pay1     = s_tdata[39:32];
    assign q_entry.extra    = s_tdata[47:40];
    assign q_entry.prof_x   = profile_reg ^ rnd;
    assign q_entry.rnd      = rnd;

endmodule

// ----- hw/rtl/abpw_queue.sv -----
// small request queue between front end and frame engine
module abpw_queue #(
    parameter int DEPTH = abpw_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  abpw_pkg::abpw_entry_t push_entry,
    input  logic                  pop,
    output logic                  full,
    output logic                  not_empty,
    output abpw_pkg::abpw_entry_t head
);
    import abpw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    abpw_entry_t      slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // queue never goes past its depth
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_FULL)
        else $error("request queue count overflow");

    // a pop always has something to take
    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> not_empty)
        else $error("pop from empty request queue");

    // full queue with no pop keeps its count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (full && !pop) |=> full)
        else $error("full queue lost an entry");

endmodule

// ----- hw/rtl/abpw_back.sv -----
// frame engine: builds, bit-reverses, whitens and streams the 31 frame bytes
module abpw_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  abpw_pkg::abpw_entry_t         q_head,
    input  abpw_pkg::abpw_cfg_t           cfg_in,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // frame_byte[7:0], byte_index[12:8], zero[15:13]
    output logic [abpw_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import abpw_pkg::*;

    localparam logic [IDX_W-1:0] HDR_END   = IDX_W'(HDR_LEN);
    localparam logic [IDX_W-1:0] REC_START = IDX_W'(REC_BASE);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [6:0]       lfsr_reg, lfsr_next;
    logic [15:0]      crca_reg, crca_next;
    logic [15:0]      crcb_reg, crcb_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg, byte_next;
    logic [IDX_W-1:0] oidx_reg, oidx_next;
    logic             last_reg, last_next;

    logic             load;
    logic             adv;
    logic [IDX_W-1:0] rec_j;
    logic [7:0]       rec_byte;
    logic [6:0]       lfsr_src;
    abpw_lfsr_t       wht;
    logic [7:0]       out_byte;
    logic [7:0]       addr [5];

    // output slot free or being drained
    assign load  = !valid_reg || m_tready;
    assign adv   = load && q_not_empty;
    assign q_pop = adv && (idx_reg == LAST_IDX);
    assign rec_j = idx_reg - REC_START;

    always_comb begin
        for (int i = 0; i < 5; i++) begin
            addr[i] = cfg_in.dev_addr[39-8*i -: 8];
        end
    end

    // logical record byte at the current position
    always_comb begin
        case (rec_j)
            5'd0:    rec_byte = addr[0][7] ? SYNC_HI : SYNC_LO;
            5'd1:    rec_byte = addr[0];
            5'd2:    rec_byte = addr[1];
            5'd3:    rec_byte = addr[2];
            5'd4:    rec_byte = addr[3];
            5'd5:    rec_byte = addr[4];
            5'd6:    rec_byte = addr[4];
            5'd7:    rec_byte = addr[4];
            5'd8:    rec_byte = q_head.cmd;
            5'd9:    rec_byte = cfg_in.grp_addr[15:8];
            5'd10:   rec_byte = cfg_in.grp_addr[7:0];
            5'd11:   rec_byte = q_head.pay0;
            5'd12:   rec_byte = q_head.pay1;
            5'd13:   rec_byte = q_head.extra;
            5'd14:   rec_byte = q_head.seq_lo;
            5'd16:   rec_byte = q_head.prof_x;
            5'd17:   rec_byte = q_head.seq_hi_x;
            5'd19:   rec_byte = q_head.rnd;
            5'd20:   rec_byte = crca_reg[15:8];
            5'd21:   rec_byte = crca_reg[7:0];
            5'd22:   rec_byte = crcb_reg[15:8];
            5'd23:   rec_byte = crcb_reg[7:0];
            default: rec_byte = 8'h00;
        endcase
    end

    // whitening restarts from the warmed-up state on the first coded byte
    assign lfsr_src = (idx_reg == HDR_END) ? LFSR_WARM : lfsr_reg;
    assign wht      = lfsr_byte(lfsr_src);

    // frame byte select: header, whitened zero prefix, or reversed and whitened record byte
    always_comb begin
        if (idx_reg < HDR_END) begin
            out_byte = hdr_byte(idx_reg);
        end else if (idx_reg < REC_START) begin
            out_byte = wht.mask;
        end else begin
            out_byte = rev8(rec_byte) ^ wht.mask;
        end
    end

    // position, whitening and running crc updates
    always_comb begin
        idx_next  = idx_reg;
        lfsr_next = lfsr_reg;
        crca_next = crca_reg;
        crcb_next = crcb_reg;
        if (adv) begin
            idx_next  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
            lfsr_next = wht.state;
            if (rec_j == 5'd8) begin
                crca_next = crc_byte({8'hFF, ~q_head.rnd}, rec_byte);
            end else if (rec_j inside {[5'd9:5'd12]}) begin
                crca_next = crc_byte(crca_reg, rec_byte);
            end
            if (rec_j == 5'd1) begin
                crcb_next = crc_byte(CRC_INIT, rec_byte);
            end else if (rec_j inside {[5'd2:5'd5], [5'd8:5'd14]}) begin
                crcb_next = crc_byte(crcb_reg, rec_byte);
            end
        end
    end

    // output register
    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        oidx_next  = oidx_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = q_not_empty;
            byte_next  = out_byte;
            oidx_next  = idx_reg;
            last_next  = (idx_reg == LAST_IDX);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        lfsr_reg <= lfsr_next;
        crca_reg <= crca_next;
        crcb_reg <= crcb_next;
        byte_reg <= byte_next;
        oidx_reg <= oidx_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, oidx_reg, byte_reg};
    assign m_tlast  = last_reg;

    // frame position stays inside the frame
    assert property (@(posedge aclk) disable iff (!aresetn) idx_reg <= LAST_IDX)
        else $error("frame position out of range");

    // last flag travels only with the final position
    assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && last_reg) |-> (oidx_reg == LAST_IDX))
        else $error("last flag on wrong frame byte");

    // a request leaves the queue in the same cycle that its final byte is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (idx_reg == '0) && valid_reg && last_reg)
        else $error("request popped before frame end");

    // each loaded byte follows the previous one in the frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && idx_reg != LAST_IDX) |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("frame position skipped");

endmodule

// ----- sim/tb_ble_adv_packet_builder_whitened.sv -----
// self-checking testbench for the whitened advertising frame builder
module tb_ble_adv_packet_builder_whitened;
    import abpw_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // one request, sequence_req in the lowest bits
    typedef struct packed {
        logic [7:0]  random_byte;
        logic [7:0]  extra_param;
        logic [7:0]  payload_byte1;
        logic [7:0]  payload_byte0;
        logic [7:0]  command_code;
        logic [15:0] sequence_req;
    } adv_request_t;

    // one expected frame byte
    typedef struct {
        logic [7:0] frame_byte;
        logic [4:0] byte_index;
        logic       last_byte;
    } frame_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    // local copy of the configuration registers
    logic [39:0] dev_addr_cfg = '0;
    logic [15:0] grp_addr_cfg = '0;
    logic [7:0]  profile_cfg  = '0;

    frame_beat_t frame_beats_due[$];
    bit          src_idle_en  = 1'b1;
    bit          sink_idle_en = 1'b1;
    int          fail_count   = 0;
    int          cycle_count  = 0;

    ble_adv_packet_builder_whitened u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // msb-first ccitt crc over one byte
    function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] d);
        logic [15:0] c;
        c = acc ^ {d, 8'h00};
        for (int b = 0; b < 8; b++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // one tick of the 7-bit whitening register, returns the mask bit
    function automatic logic whiten_step(inout logic [6:0] st);
        logic out_bit;
        out_bit = st[6];
        st = {st[5:0], out_bit};
        if (out_bit) begin
            st[4] = ~st[4];
        end
        return out_bit;
    endfunction

    // builds the expected frame for one accepted request
    function automatic void predict_frame(input adv_request_t req);
        logic [7:0]  hdr [5];
        logic [7:0]  addr_b [5];
        logic [7:0]  rec [24];
        logic [7:0]  coded [26];
        logic [15:0] crc_a;
        logic [15:0] crc_b;
        logic [6:0]  wht;
        frame_beat_t beat;
        hdr = '{8'h02, 8'h01, 8'h01, 8'h1B, 8'h03};
        for (int i = 0; i < 5; i++) begin
            addr_b[i] = dev_addr_cfg[39 - 8 * i -: 8];
        end
        // logical record
        rec[0] = addr_b[0][7] ? 8'hAA : 8'h55;
        for (int i = 0; i < 5; i++) begin
            rec[1 + i] = addr_b[i];
        end
        rec[6]  = addr_b[4];
        rec[7]  = addr_b[4];
        rec[8]  = req.command_code;
        rec[9]  = grp_addr_cfg[15:8];
        rec[10] = grp_addr_cfg[7:0];
        rec[11] = req.payload_byte0;
        rec[12] = req.payload_byte1;
        rec[13] = req.extra_param;
        rec[14] = req.sequence_req[7:0];
        rec[15] = 8'h00;
        rec[16] = profile_cfg ^ req.random_byte;
        rec[17] = req.sequence_req[15:8] ^ req.random_byte;
        rec[18] = 8'h00;
        rec[19] = req.random_byte;
        // command crc seeded from the inverted random byte
        crc_a = {8'hFF, ~req.random_byte};
        for (int i = 8; i <= 12; i++) begin
            crc_a = crc_ccitt_step(crc_a, rec[i]);
        end
        // address crc continued over record bytes 8 to 14
        crc_b = 16'hFFFF;
        for (int i = 1; i <= 5; i++) begin
            crc_b = crc_ccitt_step(crc_b, rec[i]);
        end
        for (int i = 8; i <= 14; i++) begin
            crc_b = crc_ccitt_step(crc_b, rec[i]);
        end
        rec[20] = crc_a[15:8];
        rec[21] = crc_a[7:0];
        rec[22] = crc_b[15:8];
        rec[23] = crc_b[7:0];
        // two zero bytes, then the bit-reversed record
        coded[0] = 8'h00;
        coded[1] = 8'h00;
        for (int i = 0; i < 24; i++) begin
            for (int b = 0; b < 8; b++) begin
                coded[2 + i][b] = rec[i][7 - b];
            end
        end
        // whitening after the warm-up run, lsb first
        wht = LFSR_SEED;
        for (int i = 0; i < WARMUP_BYTES * 8; i++) begin
            void'(whiten_step(wht));
        end
        for (int i = 0; i < 26; i++) begin
            for (int b = 0; b < 8; b++) begin
                coded[i][b] = coded[i][b] ^ whiten_step(wht);
            end
        end
        for (int i = 0; i < FRAME_LEN; i++) begin
            beat.frame_byte = (i < HDR_LEN) ? hdr[i] : coded[i - HDR_LEN];
            beat.byte_index = 5'(i);
            beat.last_byte  = (i == FRAME_LEN - 1);
            frame_beats_due.push_back(beat);
        end
    endfunction

    // result side: random stall after each byte when sink idling is enabled, compare against the oldest expectation
    initial begin : frame_checker
        frame_beat_t want;
        int          sink_wait;
        sink_wait = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (frame_beats_due.size() == 0) begin
                    $error("frame byte with no request pending: m_tdata=%h m_tlast=%b",
                           m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = frame_beats_due.pop_front();
                    if (m_tdata[7:0] !== want.frame_byte) begin
                        $error("frame_byte: expected %h, actual %h", want.frame_byte,
                               m_tdata[7:0]);
                        fail_count++;
                    end
                    if (m_tdata[12:8] !== want.byte_index) begin
                        $error("byte_index: expected %0d, actual %0d", want.byte_index,
                               m_tdata[12:8]);
                        fail_count++;
                    end
                    if (m_tlast !== want.last_byte) begin
                        $error("last_byte: expected %b, actual %b", want.last_byte, m_tlast);
                        fail_count++;
                    end
                end
                sink_wait = sink_idle_en ? $urandom_range(0, 7) : 0;
            end
            if (sink_wait > 0) begin
                m_tready <= 1'b0;
                sink_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one configuration write, valid stays high for a following write
    task automatic cfg_issue(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_DEV_ADDR: dev_addr_cfg = data;
            CFG_GRP_ADDR: grp_addr_cfg = data[15:0];
            CFG_PROFILE:  profile_cfg  = data[7:0];
            default: ;
        endcase
    endtask

    // all registers plus a write to the unused index, junk in the unused upper bits
    task automatic write_settings(input logic [39:0] dev, input logic [15:0] grp,
                                  input logic [7:0] prof);
        cfg_issue(CFG_SPARE, 40'({$urandom(), $urandom()}));
        cfg_issue(CFG_DEV_ADDR, dev);
        cfg_issue(CFG_GRP_ADDR, {24'($urandom()), grp});
        cfg_issue(CFG_PROFILE, {32'($urandom()), prof});
        cfg_valid <= 1'b0;
    endtask

    // one request with an optional random gap in front
    task automatic send_request(input adv_request_t req);
        int gap;
        gap = src_idle_en ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        predict_frame(req);
    endtask

    // stop sending until every expected frame byte has come back
    task automatic wait_frames_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (frame_beats_due.size() != 0);
    endtask

    // idle point for register writes
    task automatic settle_idle();
        wait_frames_done();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic adv_request_t random_request();
        adv_request_t req;
        req.sequence_req  = {pick_byte(), pick_byte()};
        req.command_code  = pick_byte();
        req.payload_byte0 = pick_byte();
        req.payload_byte1 = pick_byte();
        req.extra_param   = pick_byte();
        req.random_byte   = pick_byte();
        return req;
    endfunction

    // registers still at their reset values
    task automatic test_reset_state();
        send_request('0);
        send_request('1);
    endtask

    // field and register extremes, both sync byte choices, back-to-back requests
    task automatic test_field_extremes();
        adv_request_t req;
        settle_idle();
        write_settings('1, '1, '1);
        send_request('0);
        send_request('1);
        req = '1;
        req.random_byte = 8'h00;
        send_request(req);
        req = '0;
        req.random_byte = 8'hFF;
        send_request(req);

        settle_idle();
        write_settings(40'hAA55AA55AA, 16'h55AA, 8'h5A);
        send_request(56'hAAAAAAAAAAAAAA);
        send_request(56'h55555555555555);

        // sync byte 0x55 with every other address bit set
        settle_idle();
        write_settings(40'h7FFFFFFFFF, 16'h0000, 8'h80);
        req = '0;
        req.sequence_req = 16'h8001;
        req.random_byte  = 8'h80;
        send_request(req);
        req.sequence_req = 16'h7FFE;
        req.random_byte  = 8'h01;
        send_request(req);

        // sync byte 0xAA from the top address bit alone
        settle_idle();
        write_settings(40'h8000000000, 16'h8001, 8'h01);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (4) send_request(random_request());
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    // random requests over several settings and idling mixes
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle_idle();
            case (phase)
                0:       write_settings('0, '0, '0);
                1:       write_settings('1, '1, '1);
                default: write_settings(40'({$urandom(), $urandom()}), 16'($urandom()),
                                        8'($urandom()));
            endcase
            src_idle_en  = (phase != 1) && (phase != 3);
            sink_idle_en = (phase != 1) && (phase != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off mid-phase until the block has drained
                if (n == PHASE_ITEMS / 2) begin
                    wait_frames_done();
                end
                send_request(random_request());
            end
        end
        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_field_extremes();
        test_random_traffic();
        settle_idle();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
